>>> design/cgc_pkg.sv
// ----------------------------------------------------------------------------
// cgc_pkg: shared constants for the compressor gain computer
// Field widths, register indexes, reset values and derived pipeline sizes.
// ----------------------------------------------------------------------------
package cgc_pkg;

   // Fixed-point formats
   localparam int DB_FRAC_BITS    = 8;
   localparam int SLOPE_FRAC_BITS = 16;

   // Field widths
   localparam int DB_W       = 16;
   localparam int RATIO_W    = 16;
   localparam int KNEE_W     = 14;
   localparam int OUT_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KNEE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITER   = 2'd3;

   // Reset values
   localparam logic [DB_W-1:0]    RST_THRESHOLD = 16'hEC00;  // -20 dB
   localparam logic [RATIO_W-1:0] RST_RATIO     = 16'd1024;  // 4:1
   localparam logic [KNEE_W-1:0]  RST_KNEE      = 14'd1536;  // 6 dB
   localparam logic [RATIO_W-1:0] RST_LIMITER   = 16'd5120;  // 20:1

   // Ratio of 1.0 in dB format, one bit wider than a ratio
   localparam logic [RATIO_W:0] UNITY_RATIO = (RATIO_W+1)'(1) << DB_FRAC_BITS;

   // Largest reduction magnitude
   localparam logic [OUT_W-1:0] OUT_MIN_MAG = (OUT_W)'(1) << (OUT_W-1);

   // Soft knee: twice the distance above the knee bottom stays below 2*knee
   localparam int D2_W  = KNEE_W + 1;
   // Numerator after dropping the constant part of the divisor
   localparam int NUM_W = 2*D2_W - 3;
   // Soft-knee quotient never exceeds knee/2
   localparam int QUO_W = KNEE_W - 1;
   // Input, prep, multiply, multiply, divide stages, output
   localparam int PIPE_STAGES = QUO_W + 5;

endpackage

>>> design/compressor_gain_computer_unit.sv
// ----------------------------------------------------------------------------
// compressor_gain_computer_unit: soft-knee compressor gain computer
// Maps a detected level in dB to a gain reduction in dB, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one signed Q8.8 level word per handshake (req_valid/req_ready).
//  - rsp channel: one signed Q9.8 gain reduction word (zero or negative) for
//    every accepted word, in order (rsp_valid/rsp_ready).
//  - csr port: write enable, index and data; threshold (0), ratio (1),
//    knee width (2) and limiter ratio (3). Write only while the block is idle.
//  - Throughput: one word per cycle while the slope divider is idle and the
//    skid register is empty. Pipeline: input, prep, two multiply stages, one
//    stage per soft-knee quotient bit, output register.
//  - Slope 1 - 1/ratio comes from a bit-serial divider that runs after reset
//    and after each ratio write; while it runs, req_ready is low.
//  - Reset (synchronous, active high) empties the pipeline and loads the
//    default registers: -20 dB threshold, 4:1 ratio, 6 dB knee, 20:1 limiter.
//  - Receiver stall: the last word moves into a skid register, so the stage
//    in front keeps filling; the pipeline holds only while the skid is full.
// ----------------------------------------------------------------------------
module compressor_gain_computer_unit #(
   parameter int SLOPE_FRAC_BITS = cgc_pkg::SLOPE_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [cgc_pkg::DB_W-1:0]      req_level_db,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cgc_pkg::OUT_W-1:0]     rsp_gain_reduction_db,
   // configuration port
   input  logic                                 csr_we,
   input  logic [cgc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cgc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SF     = SLOPE_FRAC_BITS;
   localparam int MW     = SF + 1;                  // slope magnitude width
   localparam int CNT_W  = $clog2(SF + 1);
   localparam int DB_W   = cgc_pkg::DB_W;
   localparam int RW     = cgc_pkg::RATIO_W;
   localparam int KW     = cgc_pkg::KNEE_W;
   localparam int OW     = cgc_pkg::OUT_W;
   localparam int D2_W   = cgc_pkg::D2_W;
   localparam int NUM_W  = cgc_pkg::NUM_W;
   localparam int QW     = cgc_pkg::QUO_W;
   localparam int NST    = cgc_pkg::PIPE_STAGES;
   localparam int LAST   = NST - 1;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [DB_W-1:0] threshold_ff;
   logic [RW-1:0]   ratio_ff;
   logic [KW-1:0]   knee_ff;
   logic [RW-1:0]   limiter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= cgc_pkg::RST_THRESHOLD;
         ratio_ff     <= cgc_pkg::RST_RATIO;
         knee_ff      <= cgc_pkg::RST_KNEE;
         limiter_ff   <= cgc_pkg::RST_LIMITER;
      end else if (csr_we) begin
         unique case (csr_index)
            cgc_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[DB_W-1:0];
            cgc_pkg::CSR_RATIO:     ratio_ff     <= csr_wdata[RW-1:0];
            cgc_pkg::CSR_KNEE:      knee_ff      <= csr_wdata[KW-1:0];
            cgc_pkg::CSR_LIMITER:   limiter_ff   <= csr_wdata[RW-1:0];
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Slope divider: quotient of ((ratio - 1.0) << SF) / ratio, one bit a cycle
   // ------------------------------------------------------------------------
   logic             sdiv_start_ff, sdiv_start_in;
   logic             sdiv_busy_ff,  sdiv_busy_in;
   logic [CNT_W-1:0] sdiv_cnt_ff,   sdiv_cnt_in;
   logic [RW-1:0]    sdiv_rem_ff,   sdiv_rem_in;
   logic [SF-1:0]    sdiv_quo_ff,   sdiv_quo_in;
   logic [RW:0]      sdiv_shift;
   logic [RW:0]      sdiv_diff;
   logic             sdiv_ge;

   assign sdiv_shift = {sdiv_rem_ff, 1'b0};
   assign sdiv_diff  = sdiv_shift - {1'b0, ratio_ff};
   assign sdiv_ge    = sdiv_shift >= {1'b0, ratio_ff};

   always_comb begin
      sdiv_start_in = sdiv_start_ff;
      sdiv_busy_in  = sdiv_busy_ff;
      sdiv_cnt_in   = sdiv_cnt_ff;
      sdiv_rem_in   = sdiv_rem_ff;
      sdiv_quo_in   = sdiv_quo_ff;
      priority if (sdiv_start_ff) begin
         // load the partial remainder with ratio - 1.0
         sdiv_start_in = 1'b0;
         sdiv_busy_in  = 1'b1;
         sdiv_cnt_in   = CNT_W'(SF);
         sdiv_rem_in   = RW'({1'b0, ratio_ff} - cgc_pkg::UNITY_RATIO);
         sdiv_quo_in   = '0;
      end else if (sdiv_busy_ff) begin
         sdiv_rem_in  = sdiv_ge ? sdiv_diff[RW-1:0] : sdiv_shift[RW-1:0];
         sdiv_quo_in  = {sdiv_quo_ff[SF-2:0], sdiv_ge};
         sdiv_cnt_in  = sdiv_cnt_ff - CNT_W'(1);
         sdiv_busy_in = (sdiv_cnt_ff != CNT_W'(1));
      end else begin
         // idle: hold the quotient
         sdiv_busy_in = 1'b0;
      end
      // a new ratio restarts the divider
      if (csr_we && (csr_index == cgc_pkg::CSR_RATIO)) begin
         sdiv_start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sdiv_start_ff <= 1'b1;
         sdiv_busy_ff  <= 1'b0;
         sdiv_cnt_ff   <= '0;
      end else begin
         sdiv_start_ff <= sdiv_start_in;
         sdiv_busy_ff  <= sdiv_busy_in;
         sdiv_cnt_ff   <= sdiv_cnt_in;
      end
      sdiv_rem_ff <= sdiv_rem_in;
      sdiv_quo_ff <= sdiv_quo_in;
   end

   // Slope magnitude used by the datapath; pinned to 1.0 at the limiter
   logic [MW-1:0] slope_m;
   logic          unity;

   assign slope_m = (ratio_ff >= limiter_ff) ? (MW'(1) << SF) : {1'b0, sdiv_quo_ff};
   assign unity   = ({1'b0, ratio_ff} <= cgc_pkg::UNITY_RATIO);

   // ------------------------------------------------------------------------
   // Pipeline control: every stage advances while the skid register is empty
   // ------------------------------------------------------------------------
   logic           en;
   logic           req_fire;
   logic [NST-1:0] v_ff;
   logic           skid_v_ff, skid_v_in;

   assign en        = !skid_v_ff;
   assign req_ready = en && !sdiv_busy_ff && !sdiv_start_ff;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], req_fire};
      end
   end

   // ------------------------------------------------------------------------
   // Stage 0: input register
   // ------------------------------------------------------------------------
   logic [DB_W-1:0] a_level_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_level_ff <= req_level_db;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: distance from threshold, region select
   // ------------------------------------------------------------------------
   logic signed [DB_W:0]   diff;
   logic signed [DB_W+2:0] d2s;        // 2*(level - threshold) + knee
   logic signed [DB_W+2:0] knee2;      // 2*knee
   logic                   b_zero_in, b_hard_in;
   logic                   b_zero_ff, b_hard_ff;
   logic [DB_W-1:0]        b_diff_ff;
   logic [D2_W-1:0]        b_d2_ff;

   assign diff  = $signed({a_level_ff[DB_W-1], a_level_ff})
                - $signed({threshold_ff[DB_W-1], threshold_ff});
   assign d2s   = $signed({diff[DB_W], diff, 1'b0})
                + $signed({{(DB_W+3-KW){1'b0}}, knee_ff});
   assign knee2 = $signed({{(DB_W+2-KW){1'b0}}, knee_ff, 1'b0});

   always_comb begin
      b_hard_in = (knee_ff == '0) || (d2s >= knee2);
      if (knee_ff == '0) begin
         b_zero_in = unity || (diff <= 0);
      end else begin
         b_zero_in = unity || (d2s <= 0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_zero_ff <= b_zero_in;
         b_hard_ff <= b_hard_in;
         b_diff_ff <= diff[DB_W-1:0];
         b_d2_ff   <= d2s[D2_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: hard-knee product and first soft-knee product
   // ------------------------------------------------------------------------
   logic [DB_W+MW-1:0] c_hprod_in, c_hprod_ff;
   logic [MW+D2_W-1:0] c_md_in,    c_md_ff;
   logic [D2_W-1:0]    c_d2_ff;
   logic               c_zero_ff, c_hard_ff;

   assign c_hprod_in = b_diff_ff * slope_m;
   assign c_md_in    = slope_m * b_d2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c_hprod_ff <= c_hprod_in;
         c_md_ff    <= c_md_in;
         c_d2_ff    <= b_d2_ff;
         c_zero_ff  <= b_zero_ff;
         c_hard_ff  <= b_hard_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: hard-knee magnitude, soft-knee numerator m*d2*d2 >> (SF+3)
   // ------------------------------------------------------------------------
   logic [MW+2*D2_W-1:0] nprod;
   logic [OW-1:0]        hmag_in;
   logic [NUM_W-1:0]     num_in;

   assign nprod   = c_md_ff * c_d2_ff;
   assign hmag_in = c_hprod_ff[SF +: OW];
   assign num_in  = nprod[SF+3 +: NUM_W];

   // Divide stages: index 0 is stage 3, index QW feeds the output stage
   logic [NUM_W-1:0] dv_rem_ff  [0:QW];
   logic [QW-1:0]    dv_quo_ff  [0:QW];
   logic [OW-1:0]    dv_hmag_ff [0:QW];
   logic             dv_zero_ff [0:QW];
   logic             dv_hard_ff [0:QW];

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0]  <= num_in;
         dv_quo_ff[0]  <= '0;
         dv_hmag_ff[0] <= hmag_in;
         dv_zero_ff[0] <= c_zero_ff;
         dv_hard_ff[0] <= c_hard_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stages 4..QW+3: restoring division by the knee width, one bit per stage
   // ------------------------------------------------------------------------
   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int B = QW - 1 - j;
      logic [NUM_W-1:0] cmp;
      logic             ge;
      logic [NUM_W-1:0] rem_in;
      logic [QW-1:0]    quo_in;

      assign cmp    = NUM_W'(knee_ff) << B;
      assign ge     = dv_rem_ff[j] >= cmp;
      assign rem_in = ge ? (dv_rem_ff[j] - cmp) : dv_rem_ff[j];
      assign quo_in = dv_quo_ff[j] | (QW'(ge) << B);

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j+1]  <= rem_in;
            dv_quo_ff[j+1]  <= quo_in;
            dv_hmag_ff[j+1] <= dv_hmag_ff[j];
            dv_zero_ff[j+1] <= dv_zero_ff[j];
            dv_hard_ff[j+1] <= dv_hard_ff[j];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output stage: select, saturate, negate
   // ------------------------------------------------------------------------
   logic [OW-1:0] mag_sel, mag_sat, gain_in;
   logic [OW-1:0] o_gain_ff;
   logic [OW-1:0] skid_gain_ff;

   always_comb begin
      priority if (dv_zero_ff[QW]) begin
         mag_sel = '0;
      end else if (dv_hard_ff[QW]) begin
         mag_sel = dv_hmag_ff[QW];
      end else begin
         mag_sel = OW'(dv_quo_ff[QW]);
      end
      mag_sat = (mag_sel > cgc_pkg::OUT_MIN_MAG) ? cgc_pkg::OUT_MIN_MAG : mag_sel;
      gain_in = OW'(0) - mag_sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_gain_ff <= gain_in;
      end
   end

   // ------------------------------------------------------------------------
   // Skid register: catch the last word when the receiver stalls
   // ------------------------------------------------------------------------
   always_comb begin
      if (skid_v_ff) begin
         skid_v_in = !rsp_ready;
      end else begin
         skid_v_in = v_ff[LAST] && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
      end
      if (!skid_v_ff) begin
         skid_gain_ff <= o_gain_ff;
      end
   end

   assign rsp_valid             = skid_v_ff || v_ff[LAST];
   assign rsp_gain_reduction_db = skid_v_ff ? skid_gain_ff : o_gain_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   a_gain_nonpositive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gain_reduction_db[OW-1] || (rsp_gain_reduction_db == '0)))
      else $error("gain reduction is positive");

   a_skid_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(v_ff[LAST] && !rsp_ready))
      else $error("skid register filled without a receiver stall");

   a_sdiv_launch : assert property (@(posedge clock) disable iff (reset)
      sdiv_start_ff |=> (sdiv_busy_ff || sdiv_start_ff))
      else $error("slope divider did not launch");

   a_no_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (sdiv_busy_ff && !$past(sdiv_busy_ff)) |-> !v_ff[0] || !req_fire)
      else $error("word accepted while slope divider starts");
`endif

endmodule
